FILE: sv/rcps_pkg.sv
// Shared types and constants for the rounded card pixel shader.
// No dependencies; used by every other file of the block.
package rcps_pkg;

  localparam int CoordBits   = 10;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 12;
  localparam int T16Bits     = 17;  // shadow ramp, 0..65536
  localparam int Recip100    = 5243; // floor(y/100) = (y*5243)>>19 for small y
  localparam int Recip100Sh  = 19;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LIGHT_MODE    = 3'd0,
    CFG_MARGIN_PX     = 3'd1,
    CFG_PANEL_WIDTH   = 3'd2,
    CFG_PANEL_HEIGHT  = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_SHADOW_SHIFT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       interior;
  } result_t;

  typedef struct packed {
    logic        light_mode;
    logic [7:0]  margin_px;
    logic [9:0]  panel_width;
    logic [9:0]  panel_height;
    logic [11:0] corner_radius;
    logic [9:0]  shadow_shift;
  } cfg_t;

  // index 0 dark, 1 light
  localparam logic [7:0] PanelRgb [2][3] = '{'{8'd27, 8'd29, 8'd36},
                                             '{8'd252, 8'd252, 8'd253}};
  localparam logic [7:0] BorderRgb [2][3] = '{'{8'd62, 8'd66, 8'd78},
                                              '{8'd214, 8'd216, 8'd222}};
  // shadow strength times 255: 0.55 dark, 0.22 light (over 100)
  localparam logic [13:0] ShadowK [2] = '{14'd14025, 14'd5610};

endpackage

FILE: sv/rcps_dist.sv
// Signed distance pipeline: offsets, squares, pipelined square root.
// Depends on rcps_pkg.
module rcps_dist #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [rcps_pkg::CoordBits+FRAC_BITS:0] px2_i,
  input  logic [rcps_pkg::CoordBits+FRAC_BITS:0] py2_i,
  input  logic [10:0]                            ybias_i,
  input  rcps_pkg::cfg_t                         cfg_i,
  output logic                                   valid_o,
  output logic signed [FRAC_BITS+15:0]           dist_o
);

  localparam int GW = FRAC_BITS + 14;
  localparam int RW = 2 * GW;
  localparam int DW = GW + 2;

  logic [10:0] cxw, cyw;
  logic signed [GW-1:0] cx2, cy2, hx, hy;

  always_comb begin
    cxw = 11'({cfg_i.margin_px, 1'b0}) + 11'(cfg_i.panel_width);
    cyw = 11'({cfg_i.margin_px, 1'b0}) + 11'(cfg_i.panel_height);
    cx2 = signed'(GW'(cxw) << FRAC_BITS);
    cy2 = signed'(GW'(cyw) << FRAC_BITS) + signed'(GW'(ybias_i));
    hx  = signed'(GW'(cfg_i.panel_width) << FRAC_BITS)
        - signed'(GW'({cfg_i.corner_radius, 1'b0}));
    hy  = signed'(GW'(cfg_i.panel_height) << FRAC_BITS)
        - signed'(GW'({cfg_i.corner_radius, 1'b0}));
  end

  logic                 v1_q, v2_q, v3_q;
  logic signed [GW-1:0] dx_q, dy_q, qx_q, qy_q, mn_q;
  logic [RW-3:0]        sqx_q, sqy_q;
  logic [GW-2:0]        ox, oy;
  logic signed [GW-1:0] qmax;

  always_comb begin
    ox   = qx_q[GW-1] ? '0 : qx_q[GW-2:0];
    oy   = qy_q[GW-1] ? '0 : qy_q[GW-2:0];
    qmax = (qx_q > qy_q) ? qx_q : qy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= signed'(GW'(px2_i)) - cx2;
    dy_q  <= signed'(GW'(py2_i)) - cy2;
    qx_q  <= (dx_q[GW-1] ? -dx_q : dx_q) - hx;
    qy_q  <= (dy_q[GW-1] ? -dy_q : dy_q) - hy;
    sqx_q <= ox * ox;
    sqy_q <= oy * oy;
    mn_q  <= qmax[GW-1] ? qmax : '0;
  end

  // square root, one result bit per stage; slot 0 holds the sum of squares
  logic [RW-1:0]        rem_q  [GW+1];
  logic [GW-1:0]        root_q [GW+1];
  logic signed [GW-1:0] mnp_q  [GW+1];
  logic                 vp_q   [GW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q[0] <= 1'b0;
    end else begin
      vp_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(sqx_q) + RW'(sqy_q);
    root_q[0] <= '0;
    mnp_q[0]  <= mn_q;
  end

  for (genvar k = 0; k < GW; k++) begin : g_sqrt
    localparam int Bit = GW - 1 - k;
    logic [RW-1:0] delta;
    logic          take;

    always_comb begin
      delta = (RW'(root_q[k]) << (Bit + 1)) + (RW'(1) << (2 * Bit));
      take  = rem_q[k] >= delta;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vp_q[k+1] <= 1'b0;
      end else begin
        vp_q[k+1] <= vp_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= take ? rem_q[k] - delta : rem_q[k];
      root_q[k+1] <= take ? (root_q[k] | (GW'(1) << Bit)) : root_q[k];
      mnp_q[k+1]  <= mnp_q[k];
    end
  end

  logic                 vd_q;
  logic signed [DW-1:0] d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vp_q[GW];
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= signed'(DW'(root_q[GW])) + DW'(mnp_q[GW])
         - signed'(DW'({cfg_i.corner_radius, 1'b0}));
  end

  assign valid_o = vd_q;
  assign dist_o  = d_q;

endmodule

FILE: sv/rcps_shade.sv
// Shading pipeline: card coverage and border blend, shadow ramp divider and cube.
// Depends on rcps_pkg.
module rcps_shade #(
  parameter int FRAC_BITS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [FRAC_BITS+15:0] dist_i,
  input  logic signed [FRAC_BITS+15:0] sdist_i,
  input  rcps_pkg::cfg_t               cfg_i,
  output logic                         valid_o,
  output rcps_pkg::result_t            result_o
);

  localparam int DW    = FRAC_BITS + 16;
  localparam int XW    = DW + 2;
  localparam int RW    = FRAC_BITS + 9;   // shadow reach
  localparam int CovW  = FRAC_BITS + 2;
  localparam int CnW   = FRAC_BITS + 12;
  localparam int Depth = 23;              // register stages
  localparam int TB    = rcps_pkg::T16Bits;

  logic mode;
  logic [RW-1:0] reach;
  assign mode  = cfg_i.light_mode;
  assign reach = RW'(cfg_i.margin_px) << (FRAC_BITS + 1);

  logic v_q [Depth];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < Depth; i++) v_q[i] <= v_q[i-1];
    end
  end

  // ---- stage 1: clamps
  logic signed [XW-1:0] tcov, tedge, tsh;
  logic [CovW-1:0] cov_d, edge_d;
  logic [RW-1:0]   tn_d;

  always_comb begin
    tcov  = signed'(XW'(1) << FRAC_BITS) - XW'(dist_i);
    tedge = signed'(XW'(1) << (FRAC_BITS + 1)) + XW'(dist_i);
    tsh   = signed'(XW'(reach)) - XW'(sdist_i);
    if (tcov < 0) cov_d = '0;
    else if (tcov > signed'(XW'(1) << (FRAC_BITS + 1))) cov_d = CovW'(1) << (FRAC_BITS + 1);
    else cov_d = CovW'(tcov);
    if (tedge < 0) edge_d = '0;
    else if (tedge > signed'(XW'(1) << (FRAC_BITS + 1))) edge_d = CovW'(1) << (FRAC_BITS + 1);
    else edge_d = CovW'(tedge);
    if (tsh < 0) tn_d = '0;
    else if (tsh > signed'(XW'(reach))) tn_d = reach;
    else tn_d = RW'(tsh);
  end

  logic [CovW-1:0] cov_q, edge_q;
  logic            card1_q, int1_q;

  always_ff @(posedge clk_i) begin
    cov_q   <= cov_d;
    edge_q  <= edge_d;
    card1_q <= !(dist_i > 0);
    int1_q  <= dist_i < -signed'(DW'(3) << FRAC_BITS);
  end

  // ---- card path, stages 2..4
  logic [7:0]           a2_q;
  logic [CnW-1:0]       cn_q [3];
  logic                 card2_q, int2_q;
  logic [FRAC_BITS+10:0] asum;
  logic signed [CnW-1:0] cn_d [3];

  always_comb begin
    asum = (FRAC_BITS+11)'(cov_q) * (FRAC_BITS+11)'(510)
         + ((FRAC_BITS+11)'(1) << (FRAC_BITS + 1));
    for (int j = 0; j < 3; j++) begin
      cn_d[j] = signed'(CnW'(rcps_pkg::PanelRgb[mode][j]) << (FRAC_BITS + 1))
              + (signed'(CnW'(rcps_pkg::BorderRgb[mode][j]))
                 - signed'(CnW'(rcps_pkg::PanelRgb[mode][j])))
                * signed'(CnW'(edge_q));
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q    <= (asum >> (FRAC_BITS + 2)) > 255 ? 8'd255 : 8'(asum >> (FRAC_BITS + 2));
    for (int j = 0; j < 3; j++) cn_q[j] <= CnW'(cn_d[j]);
    card2_q <= card1_q;
    int2_q  <= int1_q;
  end

  logic [CnW+7:0] prod_q [3];
  logic [7:0]     a3_q;
  logic           card3_q, int3_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) prod_q[j] <= (CnW+8)'(cn_q[j]) * (CnW+8)'(a2_q);
    a3_q    <= a2_q;
    card3_q <= card2_q;
    int3_q  <= int2_q;
  end

  typedef struct packed {
    logic                 card;
    rcps_pkg::result_t    res;
  } card_word_t;

  card_word_t cw_d;
  logic [CnW+9:0] zsum;
  logic [15:0]    z;
  logic [16:0]    zr;

  always_comb begin
    cw_d.card         = card3_q;
    cw_d.res.alpha    = a3_q;
    cw_d.res.interior = int3_q;
    cw_d.res.red      = '0;
    cw_d.res.green    = '0;
    cw_d.res.blue     = '0;
    for (int j = 0; j < 3; j++) begin
      // rounded divide by 255*4S: shift, then exact /255 on 16 bits
      zsum = ((CnW+10)'(prod_q[j]) << 1) + ((CnW+10)'(510) << FRAC_BITS);
      z    = 16'(zsum >> (FRAC_BITS + 2));
      zr   = (17'(z) + 17'd1 + 17'(z >> 8)) >> 8;
      case (j)
        0:       cw_d.res.red   = zr > 255 ? 8'd255 : zr[7:0];
        1:       cw_d.res.green = zr > 255 ? 8'd255 : zr[7:0];
        default: cw_d.res.blue  = zr > 255 ? 8'd255 : zr[7:0];
      endcase
    end
  end

  // stage 4 word, delayed to stage 22
  localparam int CwLen = 19;
  card_word_t cw_q [CwLen];
  always_ff @(posedge clk_i) begin
    cw_q[0] <= cw_d;
    for (int i = 1; i < CwLen; i++) cw_q[i] <= cw_q[i-1];
  end

  // ---- shadow path: stage 1 numerator, stages 2..18 one quotient bit each
  logic [RW:0]     dr_q [TB+1];
  logic [TB-1:0]   dq_q [TB+1];

  always_ff @(posedge clk_i) begin
    dr_q[0] <= (RW+1)'(tn_d);
    dq_q[0] <= '0;
  end

  for (genvar k = 0; k < TB; k++) begin : g_div
    logic [RW:0] x;
    logic        ge;
    always_comb begin
      x  = (k == 0) ? dr_q[k] : dr_q[k] << 1;
      ge = x >= (RW+1)'(reach);
    end
    always_ff @(posedge clk_i) begin
      dr_q[k+1] <= ge ? x - (RW+1)'(reach) : x;
      dq_q[k+1] <= {dq_q[k][TB-2:0], ge};
    end
  end

  // stages 19..22: cube, scale, rounding
  logic [32:0] t2_q;
  logic [TB-1:0] t_q;
  logic [48:0] t3_q;
  logic [37:0] plo_q;
  logic [38:0] phi_q;
  logic [14:0] y_q;
  logic [63:0] nsum;

  always_comb begin
    nsum = (64'(phi_q) << 24) + 64'(plo_q) + (64'd50 << 48);
  end

  always_ff @(posedge clk_i) begin
    t2_q  <= 33'(dq_q[TB] * dq_q[TB]);
    t_q   <= dq_q[TB];
    t3_q  <= 49'(t2_q * 50'(t_q));
    plo_q <= 38'(rcps_pkg::ShadowK[mode]) * 38'(t3_q[23:0]);
    phi_q <= 39'(rcps_pkg::ShadowK[mode]) * 39'(t3_q[48:24]);
    y_q   <= nsum[62:48];
  end

  // ---- stage 23: divide by 100, select card or shadow
  logic [33:0] ymul;
  logic [14:0] ydiv;
  rcps_pkg::result_t res_d, res_q;

  always_comb begin
    ymul = 34'(y_q) * 34'(rcps_pkg::Recip100);
    ydiv = 15'(ymul >> rcps_pkg::Recip100Sh);
    res_d = cw_q[CwLen-1].res;
    if (!cw_q[CwLen-1].card) begin
      res_d       = '0;
      res_d.alpha = (cfg_i.margin_px == 8'd0) ? 8'd0
                  : (ydiv > 255 ? 8'd255 : ydiv[7:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = v_q[Depth-1];
  assign result_o = res_q;

endmodule

FILE: sv/rounded_card_pixel_shader_top.sv
// Rounded card pixel shader, top level: config registers and pipelines.
// An accepted start runs through both distance pipelines, then the shading pipeline, to the result strobe.
// Throughput one pixel per cycle while busy_o is low; depth is mostly the bit-per-stage sqrt and divider.
// The receiver cannot stall; results appear once, strobed for one cycle.
// Reset clears pipeline valids and loads default config; busy_o is high in reset.
// Depends on rcps_pkg, rcps_dist, rcps_shade.
module rounded_card_pixel_shader_top #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  rcps_pkg::pixel_t                    pixel_i,
  output logic                                result_valid_o,
  output rcps_pkg::result_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rcps_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [rcps_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int PW = rcps_pkg::CoordBits + 1 + FRAC_BITS;

  rcps_pkg::cfg_t cfg_q;
  logic busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_mode    <= 1'b0;
      cfg_q.margin_px     <= 8'd28;
      cfg_q.panel_width   <= 10'd420;
      cfg_q.panel_height  <= 10'd196;
      cfg_q.corner_radius <= 12'd224;
      cfg_q.shadow_shift  <= 10'd96;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rcps_pkg::cfg_idx_e'(cfg_index_i))
        rcps_pkg::CFG_LIGHT_MODE:    cfg_q.light_mode    <= cfg_data_i[0];
        rcps_pkg::CFG_MARGIN_PX:     cfg_q.margin_px     <= cfg_data_i[7:0];
        rcps_pkg::CFG_PANEL_WIDTH:   cfg_q.panel_width   <= cfg_data_i[9:0];
        rcps_pkg::CFG_PANEL_HEIGHT:  cfg_q.panel_height  <= cfg_data_i[9:0];
        rcps_pkg::CFG_CORNER_RADIUS: cfg_q.corner_radius <= cfg_data_i[11:0];
        rcps_pkg::CFG_SHADOW_SHIFT:  cfg_q.shadow_shift  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic [PW-1:0] px2, py2;

  // pixel centers in half-subpixel units
  assign accept = start_i && !busy_q;
  assign px2    = PW'({pixel_i.pixel_x, 1'b1}) << FRAC_BITS;
  assign py2    = PW'({pixel_i.pixel_y, 1'b1}) << FRAC_BITS;

  logic v_card, v_shad;
  logic signed [FRAC_BITS+15:0] d_card, d_shad;

  rcps_dist #(.FRAC_BITS(FRAC_BITS)) u_dist_card (
    .clk_i, .rst_ni,
    .valid_i (accept),
    .px2_i   (px2),
    .py2_i   (py2),
    .ybias_i (11'd0),
    .cfg_i   (cfg_q),
    .valid_o (v_card),
    .dist_o  (d_card)
  );

  rcps_dist #(.FRAC_BITS(FRAC_BITS)) u_dist_shad (
    .clk_i, .rst_ni,
    .valid_i (accept),
    .px2_i   (px2),
    .py2_i   (py2),
    .ybias_i ({cfg_q.shadow_shift, 1'b0}),
    .cfg_i   (cfg_q),
    .valid_o (v_shad),
    .dist_o  (d_shad)
  );

  rcps_shade #(.FRAC_BITS(FRAC_BITS)) u_shade (
    .clk_i, .rst_ni,
    .valid_i  (v_card && v_shad),
    .dist_i   (d_card),
    .sdist_i  (d_shad),
    .cfg_i    (cfg_q),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;

endmodule

FILE: sv/rcps_checker.sv
// Port-level checks for the rounded card pixel shader, bound to the top level.
// Depends on rcps_pkg and rounded_card_pixel_shader_top.
module rcps_checker #(
  parameter int FRAC_BITS = 4
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             result_valid_o,
  input rcps_pkg::result_t                result_o,
  input logic                             cfg_ready_o
);

  localparam int Lat = FRAC_BITS + 42;

  // every strobed word traces back to an accepted pixel
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without matching start");

  // premultiplied channels never exceed alpha
  a_premul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.red <= result_o.alpha) &&
                       (result_o.green <= result_o.alpha) &&
                       (result_o.blue <= result_o.alpha))
    else $error("channel above alpha");

  // deep interior is fully covered
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.interior |-> result_o.alpha == 8'd255)
    else $error("interior pixel not opaque");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> cfg_ready_o)
    else $error("config port blocked while idle");

endmodule

bind rounded_card_pixel_shader_top rcps_checker #(.FRAC_BITS(FRAC_BITS)) u_rcps_checker (.*);
